// ----- rtl/two_stage_delta_table_builder_defines.svh -----
// Assertion macros for the two-stage delta table builder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TWO_STAGE_DELTA_TABLE_BUILDER_DEFINES_SVH
`define TWO_STAGE_DELTA_TABLE_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is masked while reset is asserted
`define TSDTB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also holds during reset
`define TSDTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSDTB_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSDTB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/tsdtb_pkg.sv -----
// Shared constants for the two-stage delta table builder.
// Used by the RAM and the top level; no dependencies.
package tsdtb_pkg;

  // Code point space covered by the table
  localparam int unsigned CODE_LIMIT = 32'h10000;

  // Defaults for the top-level parameters
  localparam int unsigned BLOCK_BITS_DEF      = 7;
  localparam int unsigned STAGE_TWO_WORDS_DEF = 16384;

  // Field widths of the stream payloads
  localparam int unsigned CODE_W   = 21;
  localparam int unsigned INDEX_W  = 15;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SRC_BIG = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELTA   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // Default RAM geometry
  localparam int unsigned RAM_WIDTH_DEF = WORD_W;
  localparam int unsigned RAM_DEPTH_DEF = 1024;

endpackage

// ----- rtl/two_stage_delta_table_builder.sv -----
// Two-stage delta table builder: stage-one block offsets and stage-two deltas in two RAMs.
// Timing: the transfer edge reads both RAMs and enters the update state; the update and the result
// register follow once the result register is free; a stalled result register holds the update.
// A new item is accepted only after the read-then-write-back of the RAMs for the last one is done.
// Reset: a clearing pass over max(stage-one words, STAGE_TWO_WORDS) addresses zeroes both RAMs.
// Depends on tsdtb_pkg, tsdtb_ram and the assertion macro header.
`include "two_stage_delta_table_builder_defines.svh"

module two_stage_delta_table_builder #(
  parameter int unsigned BLOCK_BITS      = tsdtb_pkg::BLOCK_BITS_DEF,
  parameter int unsigned STAGE_TWO_WORDS = tsdtb_pkg::STAGE_TWO_WORDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [20:0] source_code, [41:21] dest_code, [56:42] read_index, [63:57] zero
  input  logic [tsdtb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] mode
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [2:0] status, [18:3] read_word, [33:19] table_size, [39:34] zero
  output logic [tsdtb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned BLOCK_SIZE = 1 << BLOCK_BITS;
  localparam int unsigned S1_WORDS   = tsdtb_pkg::CODE_LIMIT >> BLOCK_BITS;
  localparam int unsigned S1_AW      = $clog2(S1_WORDS);
  localparam int unsigned S2_AW      = $clog2(STAGE_TWO_WORDS);
  localparam int unsigned USED_W     = $clog2(STAGE_TWO_WORDS + 1);
  localparam int unsigned TSIZE_W    = $clog2(S1_WORDS + STAGE_TWO_WORDS + 1);
  localparam int unsigned CMP_W      = (TSIZE_W > tsdtb_pkg::INDEX_W) ?
                                       TSIZE_W : tsdtb_pkg::INDEX_W;
  localparam int unsigned CLR_DEPTH  = (S1_WORDS > STAGE_TWO_WORDS) ?
                                       S1_WORDS : STAGE_TWO_WORDS;
  localparam int unsigned CLR_W      = $clog2(CLR_DEPTH);
  localparam int unsigned CODE_W     = tsdtb_pkg::CODE_W;
  localparam int unsigned DIFF_W     = CODE_W + 1;

  // Sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [USED_W-1:0] used_q, used_d;

  // Held item
  logic                              mode_q;
  logic [CODE_W-1:0]                 src_q, dst_q;
  logic [tsdtb_pkg::INDEX_W-1:0]     idx_q;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic [tsdtb_pkg::STATUS_W-1:0]    out_status_q, out_status_d;
  logic [tsdtb_pkg::WORD_W-1:0]      out_word_q, out_word_d;
  logic [tsdtb_pkg::SIZE_W-1:0]      out_size_q, out_size_d;

  // RAM ports
  logic             s1_we, s1_re;
  logic [S1_AW-1:0] s1_waddr, s1_raddr;
  logic [S2_AW-1:0] s1_wdata, s1_rdata;
  logic             s2_we, s2_re;
  logic [S2_AW-1:0] s2_waddr, s2_raddr;
  logic [tsdtb_pkg::WORD_W-1:0] s2_wdata, s2_rdata;

  logic                          in_xfer, exec_fire;
  logic [CODE_W-1:0]             in_src, in_dst;
  logic [tsdtb_pkg::INDEX_W-1:0] in_idx;
  logic [CMP_W-1:0]              s2_off;

  // Insert and read evaluation
  logic              src_big, need_alloc, s2_full, range_ok;
  logic              alloc, store_delta;
  logic [S2_AW-1:0]  eff_entry, base;
  logic [DIFF_W-1:0] diff;
  logic [TSIZE_W-1:0] size_now, size_after, s1_word;
  logic              read_oob;

  assign in_src = s_axis_tdata_i[CODE_W-1:0];
  assign in_dst = s_axis_tdata_i[2*CODE_W-1:CODE_W];
  assign in_idx = s_axis_tdata_i[2*CODE_W+tsdtb_pkg::INDEX_W-1:2*CODE_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign exec_fire       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  // Issue RAM reads on the input transfer
  assign s2_off   = CMP_W'(in_idx) - CMP_W'(S1_WORDS);
  assign s1_re    = in_xfer;
  assign s2_re    = in_xfer;
  assign s1_raddr = s_axis_tuser_i ? in_idx[S1_AW-1:0] : in_src[15:BLOCK_BITS];
  assign s2_raddr = s2_off[S2_AW-1:0];

  // Evaluate the held item against the RAM read data
  always_comb begin
    src_big    = (src_q[CODE_W-1:16] != '0);
    need_alloc = (s1_rdata == '0);
    s2_full    = ({1'b0, used_q} + (USED_W+1)'(BLOCK_SIZE)) >
                 (USED_W+1)'(STAGE_TWO_WORDS);
    alloc      = !mode_q && !src_big && need_alloc && !s2_full;
    eff_entry  = need_alloc ? used_q[S2_AW-1:0] : s1_rdata;
    base       = eff_entry + S2_AW'(src_q[BLOCK_BITS-1:0]);
    diff       = {1'b0, dst_q} - {1'b0, src_q};
    range_ok   = (diff[DIFF_W-1:15] == '0) || (diff[DIFF_W-1:15] == '1);
    store_delta = !mode_q && !src_big && !(need_alloc && s2_full) && range_ok;
    used_d     = alloc ? used_q + USED_W'(BLOCK_SIZE) : used_q;
    size_now   = TSIZE_W'(S1_WORDS) + TSIZE_W'(used_q);
    size_after = TSIZE_W'(S1_WORDS) + TSIZE_W'(used_d);
    read_oob   = CMP_W'(idx_q) >= CMP_W'(size_now);
    s1_word    = TSIZE_W'(s1_rdata) + TSIZE_W'(S1_WORDS);

    out_word_d = '0;
    if (!mode_q) begin
      priority if (src_big) begin
        out_status_d = tsdtb_pkg::ST_SRC_BIG;
      end else if (need_alloc && s2_full) begin
        out_status_d = tsdtb_pkg::ST_FULL;
      end else if (!range_ok) begin
        out_status_d = tsdtb_pkg::ST_DELTA;
      end else begin
        out_status_d = tsdtb_pkg::ST_OK;
      end
    end else begin
      priority if (read_oob) begin
        out_status_d = tsdtb_pkg::ST_RANGE;
      end else if (CMP_W'(idx_q) < CMP_W'(S1_WORDS)) begin
        out_status_d = tsdtb_pkg::ST_OK;
        out_word_d   = tsdtb_pkg::WORD_W'(s1_word);
      end else begin
        out_status_d = tsdtb_pkg::ST_OK;
        out_word_d   = s2_rdata;
      end
    end
    out_size_d = tsdtb_pkg::SIZE_W'(size_after);
  end

  // RAM writes: clearing sweep or item update
  always_comb begin
    if (state_q == ST_CLEAR) begin
      s1_we    = CLR_W'(clr_cnt_q) < CLR_W'(S1_WORDS - 1) ||
                 CLR_W'(clr_cnt_q) == CLR_W'(S1_WORDS - 1);
      s1_waddr = clr_cnt_q[S1_AW-1:0];
      s1_wdata = '0;
      s2_we    = CLR_W'(clr_cnt_q) < CLR_W'(STAGE_TWO_WORDS - 1) ||
                 CLR_W'(clr_cnt_q) == CLR_W'(STAGE_TWO_WORDS - 1);
      s2_waddr = clr_cnt_q[S2_AW-1:0];
      s2_wdata = '0;
    end else begin
      s1_we    = exec_fire && alloc;
      s1_waddr = src_q[15:BLOCK_BITS];
      s1_wdata = used_q[S2_AW-1:0];
      s2_we    = exec_fire && store_delta;
      s2_waddr = base;
      s2_wdata = diff[tsdtb_pkg::WORD_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Result valid: set on update, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      used_q      <= USED_W'(BLOCK_SIZE);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (exec_fire) begin
        used_q <= used_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= s_axis_tuser_i;
      src_q  <= in_src;
      dst_q  <= in_dst;
      idx_q  <= in_idx;
    end
    if (exec_fire) begin
      out_status_q <= out_status_d;
      out_word_q   <= out_word_d;
      out_size_q   <= out_size_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {
    (tsdtb_pkg::OUT_TDATA_W - tsdtb_pkg::STATUS_W - tsdtb_pkg::WORD_W -
     tsdtb_pkg::SIZE_W)'(0),
    out_size_q, out_word_q, out_status_q};

  // Stage-one offsets
  tsdtb_ram #(
    .WIDTH (S2_AW),
    .DEPTH (S1_WORDS)
  ) u_stage_one (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_waddr),
    .wdata_i (s1_wdata),
    .re_i    (s1_re),
    .raddr_i (s1_raddr),
    .rdata_o (s1_rdata)
  );

  // Stage-two deltas
  tsdtb_ram #(
    .WIDTH (tsdtb_pkg::WORD_W),
    .DEPTH (STAGE_TWO_WORDS)
  ) u_stage_two (
    .clk_i   (clk_i),
    .we_i    (s2_we),
    .waddr_i (s2_waddr),
    .wdata_i (s2_wdata),
    .re_i    (s2_re),
    .raddr_i (s2_raddr),
    .rdata_o (s2_rdata)
  );

  `TSDTB_ASSERT(a_xfer_to_exec, clk_i, rst_ni, in_xfer |=> (state_q == ST_EXEC), "transfer did not start an update")
  `TSDTB_ASSERT(a_used_bound, clk_i, rst_ni, (USED_W+1)'(used_q) <= (USED_W+1)'(STAGE_TWO_WORDS), "stage two use beyond capacity")
  `TSDTB_ASSERT(a_delta_in_use, clk_i, rst_ni, (s2_we && (state_q == ST_EXEC)) |-> ((USED_W+1)'(s2_waddr) < (USED_W+1)'(used_d)), "delta written outside allocated blocks")
  `TSDTB_ASSERT(a_alloc_grows, clk_i, rst_ni, (s1_we && (state_q == ST_EXEC)) |=> (used_q == $past(used_q) + USED_W'(BLOCK_SIZE)), "allocation did not advance use")
  `TSDTB_ASSERT_ALWAYS(a_no_ready_in_reset, clk_i, !rst_ni |=> !s_axis_tready_o, "ready during reset")

endmodule

// ----- rtl/tsdtb_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on tsdtb_pkg for default geometry.
module tsdtb_ram #(
  parameter int unsigned WIDTH = tsdtb_pkg::RAM_WIDTH_DEF,
  parameter int unsigned DEPTH = tsdtb_pkg::RAM_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/tb_two_stage_delta_table_builder.sv -----
// Self-checking testbench for two_stage_delta_table_builder: inserts and image reads
// are checked against an in-bench table model. Depends on tsdtb_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_two_stage_delta_table_builder;

  localparam int BLOCK_BITS      = tsdtb_pkg::BLOCK_BITS_DEF;
  localparam int BLOCK_WORDS     = 1 << BLOCK_BITS;
  localparam int unsigned CODE_LIMIT = tsdtb_pkg::CODE_LIMIT;
  localparam int STAGE_ONE_WORDS = CODE_LIMIT >> BLOCK_BITS;
  localparam int STAGE_TWO_WORDS = tsdtb_pkg::STAGE_TWO_WORDS_DEF;
  localparam int MAX_CODE        = 1114111;
  localparam int CYCLE_LIMIT     = 600000;

  localparam int CODE_W      = tsdtb_pkg::CODE_W;
  localparam int INDEX_W     = tsdtb_pkg::INDEX_W;
  localparam int STATUS_W    = tsdtb_pkg::STATUS_W;
  localparam int WORD_W      = tsdtb_pkg::WORD_W;
  localparam int SIZE_W      = tsdtb_pkg::SIZE_W;
  localparam int IN_TDATA_W  = tsdtb_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = tsdtb_pkg::OUT_TDATA_W;

  localparam bit MODE_INSERT = 1'b0;
  localparam bit MODE_READ   = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic [SIZE_W-1:0]   size;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Table model state
  int unsigned block_offset [STAGE_ONE_WORDS];
  logic [WORD_W-1:0] slot_delta [STAGE_TWO_WORDS];
  int unsigned used_words;

  table_result_t expected_results [$];
  int mismatches = 0;
  int status_seen [5];
  int n_inserts = 0;
  int n_reads = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  int rx_hold_request = 0;
  int hot_sel [16];

  two_stage_delta_table_builder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Apply one request to the table model and return the result it gives
  function automatic table_result_t apply_request(bit mode, int unsigned src,
                                                  int unsigned dst, int unsigned idx);
    table_result_t r;
    int unsigned sel;
    int diff;
    r.status = tsdtb_pkg::ST_OK;
    r.word   = '0;
    if (mode == MODE_INSERT) begin
      if (src >= CODE_LIMIT) begin
        r.status = tsdtb_pkg::ST_SRC_BIG;
      end else begin
        sel  = src >> BLOCK_BITS;
        diff = int'(dst) - int'(src);
        if (block_offset[sel] == 0 && used_words + BLOCK_WORDS > STAGE_TWO_WORDS) begin
          r.status = tsdtb_pkg::ST_FULL;
        end else begin
          // allocate first, the block stays even if the delta is rejected
          if (block_offset[sel] == 0) begin
            block_offset[sel] = used_words;
            used_words += BLOCK_WORDS;
          end
          if (diff < -32768 || diff > 32767)
            r.status = tsdtb_pkg::ST_DELTA;
          else
            slot_delta[block_offset[sel] + (src & (BLOCK_WORDS - 1))] = diff[15:0];
        end
      end
    end else begin
      if (idx >= STAGE_ONE_WORDS + used_words)
        r.status = tsdtb_pkg::ST_RANGE;
      else if (idx < STAGE_ONE_WORDS)
        r.word = WORD_W'(block_offset[idx] + STAGE_ONE_WORDS);
      else
        r.word = slot_delta[idx - STAGE_ONE_WORDS];
    end
    r.size = SIZE_W'(STAGE_ONE_WORDS + used_words);
    return r;
  endfunction

  function automatic int unsigned clip_code(int v);
    if (v < 0) return 0;
    if (v > MAX_CODE) return MAX_CODE;
    return v;
  endfunction

  function automatic int unsigned table_size();
    return STAGE_ONE_WORDS + used_words;
  endfunction

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(bit mode, logic [CODE_W-1:0] src, logic [CODE_W-1:0] dst,
                           logic [INDEX_W-1:0] idx);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tdata  <= {7'b0, idx, dst, src};
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(apply_request(mode, src, dst, idx));
    if (mode == MODE_INSERT) n_inserts++;
    else n_reads++;
    @(negedge clk_i);
  endtask

  task automatic send_insert(int unsigned src, int unsigned dst);
    send_item(MODE_INSERT, CODE_W'(src), CODE_W'(dst), INDEX_W'($urandom()));
  endtask

  task automatic send_read(int unsigned idx);
    send_item(MODE_READ, CODE_W'($urandom()), CODE_W'($urandom()), INDEX_W'(idx));
  endtask

  // Drop valid and wait until every expected result is back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly well-formed traffic: inserts into a few hot blocks, reads inside the image
  task automatic send_random_item();
    int unsigned src;
    int unsigned sel;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      sel = ($urandom_range(0, 19) == 0) ? $urandom_range(0, STAGE_ONE_WORDS - 1)
                                         : hot_sel[$urandom_range(0, 15)];
      src = (sel << BLOCK_BITS) | $urandom_range(0, BLOCK_WORDS - 1);
      if ($urandom_range(0, 9) == 0)
        send_insert(src, $urandom_range(0, MAX_CODE));
      else
        send_insert(src, clip_code(int'(src) + int'($urandom_range(0, 80000)) - 40000));
    end else if (pick < 50) begin
      send_insert($urandom_range(CODE_LIMIT, MAX_CODE), $urandom_range(0, MAX_CODE));
    end else if (pick < 70) begin
      send_read($urandom_range(0, table_size() - 1));
    end else if (pick < 95) begin
      send_read($urandom_range(STAGE_ONE_WORDS, table_size() - 1));
    end else begin
      send_read($urandom_range(0, (1 << INDEX_W) - 1));
    end
  endtask

  // Reads of the empty image right after reset
  task automatic test_reset_image();
    send_read(0);
    send_read(STAGE_ONE_WORDS - 1);
    send_read(STAGE_ONE_WORDS);
    send_read(table_size() - 1);
    send_read(table_size());
    send_read((1 << INDEX_W) - 1);
  endtask

  // Field extremes, every status but stage-two full, and overwrite of a slot
  task automatic test_insert_corners();
    send_insert(CODE_LIMIT, 0);                // source too large
    send_insert(MAX_CODE, MAX_CODE);           // source too large, all-high bits
    send_insert(0, 32767);                     // largest positive delta
    send_insert(32768, 0);                     // largest negative delta
    send_insert(32767, 65535);                 // delta one above range
    send_insert(36864, 4095);                  // delta one below range
    send_insert(65535, MAX_CODE);              // new block, delta rejected
    send_insert(65535, 1048575);               // upper dest bits
    send_insert(0, 5);                         // overwrite earlier slot
    send_insert(16384, 16384);                 // zero delta
    send_read(0);
    send_read(STAGE_ONE_WORDS - 1);
    send_read(STAGE_ONE_WORDS);
    send_read(STAGE_ONE_WORDS + BLOCK_WORDS);
    send_read(table_size() - 1);
    send_read(table_size());
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < 16; i++) hot_sel[i] = $urandom_range(0, STAGE_ONE_WORDS - 1);
    repeat (count) send_random_item();
  endtask

  // Hold the result side for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_drain();
    rx_hold_request = 300;
    repeat (30) send_random_item();
  endtask

  // Pause the sender until the block is empty, then resume
  task automatic test_sender_pause();
    wait_drain();
    repeat (25) @(negedge clk_i);
    repeat (20) send_random_item();
  endtask

  // Allocate blocks until stage two runs out, then keep inserting
  task automatic test_fill_stage_two();
    int unsigned src;
    for (int k = 0; k < STAGE_ONE_WORDS; k++) begin
      src = (((k * 37) % STAGE_ONE_WORDS) << BLOCK_BITS) | $urandom_range(0, BLOCK_WORDS - 1);
      send_insert(src, clip_code(int'(src) + int'($urandom_range(0, 2000)) - 1000));
    end
    repeat (64) begin
      src = $urandom_range(0, CODE_LIMIT - 1);
      send_insert(src, clip_code(int'(src) + int'($urandom_range(0, 600)) - 300));
    end
  endtask

  // Last stretch at full rate: reads over the whole image and both ends
  task automatic test_full_image_reads();
    no_idle = 1'b1;
    send_read(table_size() - 1);
    send_read(table_size());
    repeat (300) begin
      if ($urandom_range(0, 3) == 0) send_random_item();
      else send_read($urandom_range(0, table_size() - 1));
    end
  endtask

  // Result side: random stall bursts plus the long hold on request
  always @(negedge clk_i) begin
    static int stall_left = 0;
    if (rx_hold_request != 0) begin
      stall_left = rx_hold_request;
      rx_hold_request = 0;
    end else if (stall_left == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got.status = m_axis_tdata_o[2:0];
      got.word   = m_axis_tdata_o[18:3];
      got.size   = m_axis_tdata_o[33:19];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with none expected: status=%0d word=%h size=%0d",
                   got.status, got.word, got.size);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.word !== want.word || got.size !== want.size) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: status %0d/%0d word %h/%h size %0d/%0d (expected/actual)",
                     want.status, got.status, want.word, got.word, want.size, got.size);
        end
        if (want.status <= tsdtb_pkg::ST_RANGE) status_seen[want.status]++;
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < STAGE_ONE_WORDS; i++) block_offset[i] = 0;
    for (int i = 0; i < STAGE_TWO_WORDS; i++) slot_delta[i] = '0;
    used_words = BLOCK_WORDS;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_image();
    test_insert_corners();
    test_random_mix(1200);
    test_backpressure();
    test_sender_pause();
    test_fill_stage_two();
    test_full_image_reads();

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $display("ERROR: %0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("Covered %0d inserts and %0d image reads; stage-two words in use: %0d",
             n_inserts, n_reads, used_words);
    $display("Statuses seen: ok=%0d src_big=%0d full=%0d delta=%0d range=%0d; mismatches=%0d",
             status_seen[tsdtb_pkg::ST_OK], status_seen[tsdtb_pkg::ST_SRC_BIG],
             status_seen[tsdtb_pkg::ST_FULL], status_seen[tsdtb_pkg::ST_DELTA],
             status_seen[tsdtb_pkg::ST_RANGE], mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
